// ----- rtl/core/ultrasonic_echo_ranger_defines.svh -----
// assertion macros for the echo ranger
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every clock edge outside reset
`define UER_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true outside reset
`define UER_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define UER_ASSERT(lbl, clk, rstn, prop, msg)
`define UER_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ----- rtl/core/uer_pkg.sv -----
package uer_pkg;

  localparam int unsigned FIFO_DEPTH   = 128;
  localparam int unsigned PTR_BITS     = $clog2(FIFO_DEPTH);
  localparam int unsigned COUNT_BITS   = 24;
  localparam int unsigned WIDTH_BITS   = 24;
  localparam int unsigned TRIG_BITS    = 16;
  localparam int unsigned IN_DATA_BITS = 8;
  localparam int unsigned OUT_DATA_BITS = 32;

  localparam logic [TRIG_BITS-1:0] TRIG_LEN_RST = TRIG_BITS'(600);

  typedef logic [PTR_BITS-1:0]   ptr_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [TRIG_BITS-1:0]  trig_t;

  typedef enum logic [1:0] {
    ACT_IDLE  = 2'd0,
    ACT_START = 2'd1,
    ACT_POP   = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

endpackage

// ----- rtl/core/ultrasonic_echo_ranger.sv -----
// ultrasonic echo ranger: trigger pulse generation and echo width capture
// path: a word accepted on the slave side is held in the input register, then
//   processed into the result register once that is free or being drained
// throughput: one word per cycle while the master side accepts results
// reset: async active low, clears control state and pointers, trig_len to 600;
//   fifo storage is not cleared, entries are read only after being written
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger import uer_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config: trig_len
  input  logic                     cfg_we_i,
  input  logic [TRIG_BITS-1:0]     cfg_wdata_i,
  // slave side
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [1:0] action, [2] echo_level, rest zero
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // master side
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [0] trig_level, [24:1] read_width, [25] buffer_empty, [26] buffer_full, rest zero
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,
  // [0] read_valid
  output logic                     m_axis_tuser_o
);

  // configuration register
  trig_t trig_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_len_q <= TRIG_LEN_RST;
    end else if (cfg_we_i) begin
      trig_len_q <= cfg_wdata_i;
    end
  end

  // input register
  logic       in_valid_q, in_valid_d;
  logic [1:0] action_q;
  logic       echo_q;
  logic       in_accept;
  logic       proc;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic                   trig_level_q;
  logic [WIDTH_BITS-1:0]  read_width_q;
  logic                   read_valid_q;
  logic                   buf_empty_q;
  logic                   buf_full_q;

  // the tick is processed once the result register is free or being drained
  assign proc            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= s_axis_tdata_i[1:0];
      echo_q   <= s_axis_tdata_i[2];
    end
  end

  // tick state
  logic  echo_prev_q, echo_prev_d;
  logic  measuring_q, measuring_d;
  cnt_t  elapsed_q, elapsed_d;
  trig_t trig_rem_q, trig_rem_d;
  ptr_t  rd_ptr_q, rd_ptr_d;
  ptr_t  wr_ptr_q, wr_ptr_d;

  // width storage with a prefetched head word
  cnt_t  width_mem [FIFO_DEPTH];
  cnt_t  head_q;

  logic  rising, falling, fire, push, pop_ok, push_ok;
  logic  empty_now, full_after_pop;
  logic  trig_level;
  trig_t trig_loaded;
  cnt_t  elapsed_inc;
  ptr_t  rd_ptr_inc;
  ptr_t  wr_ptr_inc;

  always_comb begin
    rising      = echo_q && !echo_prev_q;
    falling     = !echo_q && echo_prev_q;
    fire        = (action_q == ACT_START);
    push        = 1'b0;
    measuring_d = measuring_q;
    elapsed_d   = elapsed_q;
    // saturating tick count
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + cnt_t'(1);

    if (rising) begin
      measuring_d = 1'b1;
      elapsed_d   = '0;
    end else if (measuring_q) begin
      elapsed_d = elapsed_inc;
      if (falling) begin
        push        = 1'b1;
        measuring_d = 1'b0;
      end
    end else if (falling) begin
      // falling edge with no rising edge seen: retrigger
      fire = 1'b1;
    end

    // trigger pulse counts down from trig_len, high while nonzero
    trig_loaded = fire ? trig_len_q : trig_rem_q;
    trig_level  = (trig_loaded != '0);
    trig_rem_d  = trig_level ? trig_loaded - trig_t'(1) : trig_loaded;

    // pop first from the fifo as it stood, then push
    empty_now      = (rd_ptr_q == wr_ptr_q);
    pop_ok         = (action_q == ACT_POP) && !empty_now;
    rd_ptr_inc     = rd_ptr_q + ptr_t'(1);
    rd_ptr_d       = pop_ok ? rd_ptr_inc : rd_ptr_q;
    wr_ptr_inc     = wr_ptr_q + ptr_t'(1);
    full_after_pop = (wr_ptr_inc == rd_ptr_d);
    push_ok        = push && !full_after_pop;
    wr_ptr_d       = push_ok ? wr_ptr_inc : wr_ptr_q;

    echo_prev_d = echo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_prev_q <= 1'b0;
      measuring_q <= 1'b0;
      elapsed_q   <= '0;
      trig_rem_q  <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
    end else if (proc) begin
      echo_prev_q <= echo_prev_d;
      measuring_q <= measuring_d;
      elapsed_q   <= elapsed_d;
      trig_rem_q  <= trig_rem_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
    end
  end

  // memory: one write port, one registered read of the next head
  logic mem_we;
  ptr_t head_addr;

  assign mem_we    = proc && push_ok;
  assign head_addr = proc ? rd_ptr_d : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      width_mem[wr_ptr_q] <= elapsed_d;
    end
    // bypass when the word just written becomes the head
    if (mem_we && (wr_ptr_q == head_addr)) begin
      head_q <= elapsed_d;
    end else begin
      head_q <= width_mem[head_addr];
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      trig_level_q <= trig_level;
      read_width_q <= pop_ok ? WIDTH_BITS'(head_q) : '0;
      read_valid_q <= pop_ok;
      buf_empty_q  <= (rd_ptr_d == wr_ptr_d);
      buf_full_q   <= ((wr_ptr_d + ptr_t'(1)) == rd_ptr_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = read_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_BITS - WIDTH_BITS - 3)'(0), buf_full_q, buf_empty_q,
                            read_width_q, trig_level_q};

  // checks
  `UER_ASSERT(a_pop_moves_head, clk_i, rst_ni, proc && (action_q == ACT_POP) && (rd_ptr_q != wr_ptr_q) |=> rd_ptr_q == $past(rd_ptr_q) + ptr_t'(1), "valid pop did not advance read pointer")
  `UER_ASSERT(a_ptrs_hold_idle, clk_i, rst_ni, !proc |=> $stable(rd_ptr_q) && $stable(wr_ptr_q), "fifo pointers moved without a tick")
  `UER_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i, "input stalled without a blocked result")
  `UER_ASSERT_NEVER(a_valid_pop_empty, clk_i, rst_ni, proc && pop_ok && empty_now, "pop served from an empty fifo")

endmodule
